/* rtl/u16u8_pkg.sv */
package u16u8_pkg;

    // One decoded unit: up to four UTF-8 bytes, sent from index 0 up to last_idx.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            done;
        logic            bad;
    } u16u8_job_t;

    localparam int unsigned CuWidth = 16;
    localparam int unsigned CpWidth = 21;

    localparam logic [5:0] HighPrefix = 6'b110110;
    localparam logic [5:0] LowPrefix  = 6'b110111;
    localparam logic [4:0] SurrPrefix = 5'b11011;
    localparam logic [CpWidth-1:0] SuppBase = 21'h10000;

endpackage

/* rtl/utf16_to_utf8_transcoder.sv */
// The first byte of a unit is registered in the queue, then in the output register.
// The back end sends one output byte per cycle while out_ready holds; a unit
// gives 1 to 4 bytes (its byte count), so a BMP unit gives at most 3 bytes.
// Surrogate-store and discarded units produce no bytes.
// Reset (rst_n, async, active low) empties the queue and clears surrogate state.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // last_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // [0] string_done, [1] bad_input
);

    logic       q_full, push, pop, head_valid;
    u16u8_job_t push_job, head_job;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .code_unit (s_axis_tdata),
        .last_unit (s_axis_tlast),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_job  (push_job)
    );

    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u16u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .last_of_run (m_axis_tlast),
        .string_done (m_axis_tuser[0]),
        .bad_input   (m_axis_tuser[1])
    );

endmodule

/* rtl/u16u8_front.sv */
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [CuWidth-1:0]  code_unit,
    input  logic                last_unit,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output u16u8_job_t          push_job
);

    logic       have_hs_reg, have_hs_next;
    logic [9:0] hs_bits_reg, hs_bits_next;
    logic       discard_reg, discard_next;

    logic       accept;
    logic       is_high, is_low, is_surr;
    logic [CpWidth-1:0] pair_cp;

    function automatic u16u8_job_t encode(input logic [CpWidth-1:0] cp, input logic last);
        u16u8_job_t j;
        j = '0;
        j.done = last;
        if (cp < 21'h80) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    function automatic u16u8_job_t error_job();
        u16u8_job_t j;
        j = '0;
        j.done = 1'b1;
        j.bad  = 1'b1;
        return j;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_high = code_unit[15:10] == HighPrefix;
    assign is_low  = code_unit[15:10] == LowPrefix;
    assign is_surr = code_unit[15:11] == SurrPrefix;
    assign pair_cp = SuppBase + {1'b0, hs_bits_reg, code_unit[9:0]};

    always_comb
    begin
        have_hs_next = have_hs_reg;
        hs_bits_next = hs_bits_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_job     = '0;
        if (accept)
        begin
            if (discard_reg)
            begin
                if (last_unit)
                    discard_next = 1'b0;
            end else if (have_hs_reg)
            begin
                have_hs_next = 1'b0;
                hs_bits_next = '0;
                push         = 1'b1;
                if (is_low)
                    push_job = encode(pair_cp, last_unit);
                else
                begin
                    push_job     = error_job();
                    discard_next = !last_unit;
                end
            end else if (!is_surr)
            begin
                push     = 1'b1;
                push_job = encode({5'd0, code_unit}, last_unit);
            end else if (is_high && !last_unit)
            begin
                have_hs_next = 1'b1;
                hs_bits_next = code_unit[9:0];
            end else
            begin
                // lone low surrogate, or high surrogate ending the string
                push         = 1'b1;
                push_job     = error_job();
                discard_next = !last_unit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_hs_reg <= 1'b0;
            hs_bits_reg <= '0;
            discard_reg <= 1'b0;
        end else
        begin
            have_hs_reg <= have_hs_next;
            hs_bits_reg <= hs_bits_next;
            discard_reg <= discard_next;
        end
    end

endmodule

/* rtl/u16u8_queue.sv */
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u16u8_job_t push_job,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output u16u8_job_t head_job
);

    u16u8_job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/u16u8_back.sv */
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  u16u8_job_t head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_done,
    output logic       bad_input
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       lor_reg, lor_next;
    logic       done_reg, done_next;
    logic       bad_reg, bad_next;
    logic       load, fin;

    assign load = head_valid && (!valid_reg || out_ready);
    assign fin  = idx_reg == head_job.last_idx;
    assign pop  = load && fin;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        lor_next   = lor_reg;
        done_next  = done_reg;
        bad_next   = bad_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = head_job.bytes[idx_reg];
            lor_next   = fin;
            done_next  = fin && head_job.done;
            bad_next   = head_job.bad;
            idx_next   = fin ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        lor_reg  <= lor_next;
        done_reg <= done_next;
        bad_reg  <= bad_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = lor_reg;
    assign string_done = done_reg;
    assign bad_input   = bad_reg;

endmodule

/* test/tb_utf16_to_utf8_transcoder.sv */
module tb_utf16_to_utf8_transcoder;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AT_UNIT   = 160;
    localparam int PHASE_UNITS    = 52;

    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;
    localparam logic [4:0] SURR_TAG = 5'b11011;

    typedef struct packed {
        logic [15:0] cu;
        logic        fin;
    } utf16_unit_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_done;
        logic       bad;
    } utf8_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    utf16_unit_t  utf16_units[$];
    utf8_result_t utf8_expected[$];

    // predictor state
    logic       pend_high = 1'b0;
    logic [9:0] pend_bits = 10'd0;
    logic       dropping = 1'b0;

    int  send_idle_pct = 24;
    int  recv_idle_pct = 87;
    int  units_loaded = 0;
    int  units_accepted = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  unit_taken = 1'b0;

    utf16_to_utf8_transcoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic push_error(input logic fin);
        utf8_expected.push_back('{data: 8'h00, run_end: 1'b1, str_done: 1'b1, bad: 1'b1});
        pend_high = 1'b0;
        pend_bits = 10'd0;
        dropping  = !fin;
    endtask

    // Expected UTF-8 bytes for one accepted code unit.
    task automatic transcode_unit(input logic [15:0] cu, input logic fin);
        logic [20:0] cp;
        logic [7:0]  b [4];
        int          n;
        if (dropping)
        begin
            if (fin)
                dropping = 1'b0;
            return;
        end
        if (pend_high)
        begin
            if (cu[15:10] != LOW_TAG)
            begin
                push_error(fin);
                return;
            end
            cp = 21'h10000 + {1'b0, pend_bits, cu[9:0]};
            pend_high = 1'b0;
            pend_bits = 10'd0;
        end
        else if (cu[15:11] != SURR_TAG)
            cp = {5'd0, cu};
        else if (cu[15:10] == HIGH_TAG && !fin)
        begin
            pend_high = 1'b1;
            pend_bits = cu[9:0];
            return;
        end
        else
        begin
            // lone low surrogate, or high surrogate closing the string
            push_error(fin);
            return;
        end
        if (cp < 21'h80)
        begin
            b[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800)
        begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp < 21'h10000)
        begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else
        begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
            utf8_expected.push_back('{data: b[k], run_end: (k == n - 1),
                                      str_done: (k == n - 1) && fin, bad: 1'b0});
    endtask

    task automatic add_unit(input logic [15:0] cu, input logic fin);
        utf16_units.push_back('{cu: cu, fin: fin});
        units_loaded++;
    endtask

    // Mostly well-formed strings with a sprinkling of broken surrogates.
    task automatic add_random_string();
        logic [15:0] units[$];
        int          len;
        int          kind;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
                units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
            else if (kind < 45)
                units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
            else if (kind < 70)
                units.push_back($urandom_range(0, 1)
                                ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                : 16'($urandom_range(16'hE000, 16'hFFFF)));
            else if (kind < 90)
            begin
                units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
                units.push_back(16'hDC00 | 16'($urandom_range(0, 1023)));
            end
            else if (kind < 94)
                units.push_back(16'($urandom_range(0, 16'hFFFF)));
            else if (kind < 97)
                units.push_back(16'hDC00 | 16'($urandom_range(0, 1023)));
            else
                units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
        end
        if ($urandom_range(0, 99) < 8)
            units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
        foreach (units[k])
            add_unit(units[k], k == units.size() - 1);
    endtask

    task automatic drain();
        while (utf16_units.size() != 0 || utf8_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int snd_pct, input int rcv_pct);
        int target;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        target = units_loaded + PHASE_UNITS;
        while (units_loaded < target)
            add_random_string();
        drain();
    endtask

    // Sender: holds an offer until its transaction completes.
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !unit_taken))
        begin
            if (utf16_units.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= utf16_units[0].cu;
                s_axis_tlast  <= utf16_units[0].fin;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        unit_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (unit_taken)
        begin
            transcode_unit(s_axis_tdata, s_axis_tlast);
            void'(utf16_units.pop_front());
            units_accepted++;
        end
    end

    // Receiver, with one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && units_accepted >= HOLD_AT_UNIT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        utf8_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (utf8_expected.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none actual %02h %0b %02b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                exp_r = utf8_expected.pop_front();
                if (m_axis_tdata !== exp_r.data)
                begin
                    $display("%0t out_byte: expected %02h actual %02h",
                             $time, exp_r.data, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== exp_r.run_end)
                begin
                    $display("%0t last_of_run: expected %0b actual %0b",
                             $time, exp_r.run_end, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== exp_r.str_done)
                begin
                    $display("%0t string_done: expected %0b actual %0b",
                             $time, exp_r.str_done, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== exp_r.bad)
                begin
                    $display("%0t bad_input: expected %0b actual %0b",
                             $time, exp_r.bad, m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n);
        // range edges of each encoding length
        add_unit(16'h0000, 1'b0);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hD7FF, 1'b0);
        add_unit(16'hE000, 1'b0);
        add_unit(16'hFFFF, 1'b1);
        // lowest and highest surrogate pairs
        add_unit(16'hD800, 1'b0);
        add_unit(16'hDC00, 1'b1);
        add_unit(16'hDBFF, 1'b0);
        add_unit(16'hDFFF, 1'b0);
        // high surrogate closing the string
        add_unit(16'hDBFF, 1'b1);
        // lone low surrogate, rest of string dropped
        add_unit(16'hDC00, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'h0042, 1'b1);
        // high surrogate followed by a plain unit
        add_unit(16'hD800, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'h0000, 1'b1);
        // high surrogate followed by another high, at end of string
        add_unit(16'hD801, 1'b0);
        add_unit(16'hDBFF, 1'b1);
        // lone low surrogate as the last unit
        add_unit(16'hDFFF, 1'b1);
        add_unit(16'h0041, 1'b1);
        drain();

        run_random_phase(24, 87);
        run_random_phase(87, 24);
        run_random_phase(0, 0);

        repeat (30) @(posedge clk);
        if (mismatches == 0 && utf8_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
